/* sv/iflf_pkg.sv */
// ----------------------------------------------------------------------------
// iflf_pkg
// Shared codes for the first-fit header-list allocator.
// ----------------------------------------------------------------------------
package iflf_pkg;

  localparam int HDR_BYTES = 8;
  localparam int MIN_BLOCK = 16;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 56;

  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_FREE     = 3'd1;
  localparam logic [2:0] CMD_RESIZE   = 3'd2;
  localparam logic [2:0] CMD_FORMAT   = 3'd3;
  localparam logic [2:0] CMD_VALIDATE = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_NOTFMT  = 3'd3;
  localparam logic [2:0] ST_FMTREJ  = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;
  localparam logic [2:0] ST_IGNORED = 3'd6;

endpackage

/* sv/iflf_ram.sv */
// ----------------------------------------------------------------------------
// iflf_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module iflf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/implicit_list_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator
// Header-only heap manager: format, first-fit allocate, free, resize and
// validate over a header RAM with one entry per 8 bytes.
// ----------------------------------------------------------------------------
// channel  direction  beat contents
// in_      slave      command, request size, pointer flag, payload offset
// out_     master     status, result offset, copy source, copy length
// cfg_     write      heap base (index 0), heap size (index 1)
//
// Each command is one beat in and one beat out. Free and a shrinking resize
// read one header and write it back; allocate and validate walk the headers
// through the single RAM port, and allocate then writes its headers. Reset
// clears the control state only; the header RAM is written by format. A new
// command is accepted while the last result still waits on out_tready.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator
  import iflf_pkg::*;
#(
  parameter int HEAP_BYTES  = 65536,
  parameter int ALIGN_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // cmd[2:0], request_bytes[18:3], has_pointer[19], payload_offset[35:20]
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[2:0], result_offset[18:3], copy_from_offset[34:19], copy_bytes[50:35]
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [47:0]       cfg_wdata
);

  localparam int PW    = $clog2(HEAP_BYTES) + 1;
  localparam int CW    = (PW > 18) ? PW : 18;
  localparam int SLOTS = HEAP_BYTES / 8;
  localparam int AW    = $clog2(SLOTS);
  localparam int EW    = PW - 2;

  localparam logic [CW-1:0] AMSK_C = CW'(ALIGN_BYTES - 1);
  localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);
  localparam logic [CW-1:0] MINB_C = CW'(MIN_BLOCK);
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] M_ALLOC = 2'd0;
  localparam logic [1:0] M_VAL   = 2'd1;
  localparam logic [1:0] M_FREE  = 2'd2;
  localparam logic [1:0] M_RSZ   = 2'd3;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          move_r, move_nxt;
  logic [2:0]    fr_ok_r, fr_ok_nxt;
  logic [15:0]   req_r, req_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] wpos_r, wpos_nxt;
  logic [EW-1:0] wval_r, wval_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [15:0]   res_r, res_nxt;
  logic [15:0]   cfrom_r, cfrom_nxt;
  logic [15:0]   cbytes_r, cbytes_nxt;
  logic          ready_r, ready_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic [47:0]   base_r;
  logic [16:0]   bytes_r;
  logic          ov_r;
  logic [OUT_W-1:0] od_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  iflf_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [2:0]    i_cmd;
  logic [15:0]   i_req, i_off;
  logic          i_hp;
  logic [CW-1:0] i_need, i_offc, i_endc, fmt_bytes, fmt_total;
  logic          i_ptr_ok, fmt_ok;
  logic [CW-1:0] rd_sz, posc, room, rem, old_pay, hdrc;
  logic          rd_alloc, load_out;

  assign i_cmd = in_tdata[2:0];
  assign i_req = in_tdata[18:3];
  assign i_hp  = in_tdata[19];
  assign i_off = in_tdata[35:20];

  assign i_need   = ((CW'(i_req) + AMSK_C) & ~AMSK_C) + HDR_C;
  assign i_offc   = CW'(i_off);
  assign i_endc   = CW'(end_r);
  assign i_ptr_ok = (i_offc >= HDR_C) && ((i_offc - HDR_C) < i_endc)
                    && ((i_offc & AMSK_C) == '0);
  assign fmt_bytes = (CW'(bytes_r) > HEAP_C) ? HEAP_C : CW'(bytes_r);
  assign fmt_total = fmt_bytes & ~AMSK_C;
  assign fmt_ok    = (base_r != '0) && ((CW'(base_r[7:0]) & AMSK_C) == '0)
                     && (fmt_total >= MINB_C);

  assign rd_sz    = CW'({ram_rdata[EW-1:1], 3'b000});
  assign rd_alloc = ram_rdata[0];
  assign posc     = CW'(pos_r);
  assign room     = i_endc - posc;
  assign rem      = rd_sz - need_r;
  assign old_pay  = rd_sz - HDR_C;
  assign hdrc     = CW'(off_r) - HDR_C;

  assign in_tready = (state_r == S_IDLE);
  assign load_out  = (state_r == S_DONE) && (!ov_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    move_nxt   = move_r;
    fr_ok_nxt  = fr_ok_r;
    req_nxt    = req_r;
    off_nxt    = off_r;
    need_nxt   = need_r;
    pos_nxt    = pos_r;
    wpos_nxt   = wpos_r;
    wval_nxt   = wval_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    cfrom_nxt  = cfrom_r;
    cbytes_nxt = cbytes_r;
    ready_nxt  = ready_r;
    end_nxt    = end_r;
    ram_we     = 1'b0;
    ram_addr   = pos_r[AW+2:3];
    ram_wdata  = wval_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = i_req;
          off_nxt    = i_off;
          need_nxt   = i_need;
          move_nxt   = 1'b0;
          res_nxt    = '0;
          cfrom_nxt  = '0;
          cbytes_nxt = '0;
          pos_nxt    = '0;
          state_nxt  = S_DONE;
          case (i_cmd)
            CMD_ALLOC: begin
              if (i_req == '0) begin
                st_nxt = ST_NONE;
              end else if (!ready_r) begin
                st_nxt = ST_NOTFMT;
              end else begin
                mode_nxt  = M_ALLOC;
                state_nxt = S_RD;
              end
            end
            CMD_FREE: begin
              if (!i_hp) begin
                st_nxt = ST_NONE;
              end else if (!ready_r) begin
                st_nxt = ST_NOTFMT;
              end else if (!i_ptr_ok) begin
                st_nxt = ST_IGNORED;
              end else begin
                mode_nxt  = M_FREE;
                fr_ok_nxt = ST_OK;
                pos_nxt   = PW'(i_offc - HDR_C);
                state_nxt = S_RD;
              end
            end
            CMD_RESIZE: begin
              if (!i_hp) begin
                if (i_req == '0) begin
                  st_nxt = ST_NONE;
                end else if (!ready_r) begin
                  st_nxt = ST_NOTFMT;
                end else begin
                  mode_nxt  = M_ALLOC;
                  state_nxt = S_RD;
                end
              end else if (!ready_r) begin
                st_nxt = ST_NOTFMT;
              end else if (!i_ptr_ok) begin
                st_nxt = ST_IGNORED;
              end else begin
                mode_nxt  = (i_req == '0) ? M_FREE : M_RSZ;
                fr_ok_nxt = ST_NONE;
                pos_nxt   = PW'(i_offc - HDR_C);
                state_nxt = S_RD;
              end
            end
            CMD_FORMAT: begin
              ready_nxt = 1'b0;
              end_nxt   = '0;
              if (!fmt_ok) begin
                st_nxt = ST_FMTREJ;
              end else begin
                st_nxt    = ST_OK;
                ready_nxt = 1'b1;
                end_nxt   = PW'(fmt_total);
                wpos_nxt  = '0;
                wval_nxt  = EW'(fmt_total >> 2);
                state_nxt = S_WR2;
              end
            end
            CMD_VALIDATE: begin
              if (!ready_r) begin
                st_nxt = ST_NOTFMT;
              end else begin
                mode_nxt  = M_VAL;
                state_nxt = S_RD;
              end
            end
            default: begin
              st_nxt = ST_NONE;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        case (mode_r)
          M_ALLOC: begin
            if (rd_sz < MINB_C || rd_sz > room) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else if (!rd_alloc && rd_sz >= need_r) begin
              ram_we    = 1'b1;
              st_nxt    = ST_OK;
              res_nxt   = 16'(posc + HDR_C);
              if (rem >= MINB_C) begin
                ram_wdata = EW'((need_r >> 2) | CW'(1));
                wpos_nxt  = PW'(posc + need_r);
                wval_nxt  = EW'(rem >> 2);
                state_nxt = S_WR2;
              end else begin
                ram_wdata = EW'((rd_sz >> 2) | CW'(1));
                if (move_r) begin
                  mode_nxt  = M_FREE;
                  pos_nxt   = PW'(hdrc);
                  state_nxt = S_RD;
                end else begin
                  state_nxt = S_DONE;
                end
              end
            end else begin
              pos_nxt = PW'(posc + rd_sz);
              if ((posc + rd_sz) >= i_endc) begin
                st_nxt    = ST_NOFIT;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
          end
          M_VAL: begin
            if ((rd_sz & AMSK_C) != '0 || rd_sz < MINB_C || room < rd_sz) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              pos_nxt = PW'(posc + rd_sz);
              if ((posc + rd_sz) >= i_endc) begin
                st_nxt    = ST_OK;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
          end
          M_FREE: begin
            state_nxt = S_DONE;
            if (rd_alloc) begin
              ram_we    = 1'b1;
              ram_wdata = {ram_rdata[EW-1:1], 1'b0};
            end
            if (!move_r) begin
              st_nxt = rd_alloc ? fr_ok_r : ST_IGNORED;
            end
          end
          default: begin
            if (rd_sz < MINB_C || rd_sz > room) begin
              st_nxt    = ST_IGNORED;
              state_nxt = S_DONE;
            end else if (need_r <= rd_sz) begin
              st_nxt  = ST_OK;
              res_nxt = off_r;
              if (rem >= MINB_C) begin
                ram_we    = 1'b1;
                ram_wdata = EW'((need_r >> 2) | CW'(1));
                wpos_nxt  = PW'(posc + need_r);
                wval_nxt  = EW'(rem >> 2);
                state_nxt = S_WR2;
              end else begin
                state_nxt = S_DONE;
              end
            end else begin
              move_nxt   = 1'b1;
              cfrom_nxt  = off_r;
              cbytes_nxt = (old_pay < CW'(req_r)) ? 16'(old_pay) : req_r;
              mode_nxt   = M_ALLOC;
              pos_nxt    = '0;
              state_nxt  = S_RD;
            end
          end
        endcase
      end
      S_WR2: begin
        ram_we    = 1'b1;
        ram_addr  = wpos_r[AW+2:3];
        ram_wdata = wval_r;
        if (move_r) begin
          mode_nxt  = M_FREE;
          pos_nxt   = PW'(hdrc);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
      end_r   <= '0;
      base_r  <= '0;
      bytes_r <= 17'd65536;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
      end_r   <= end_nxt;
      if (cfg_we) begin
        if (cfg_addr) begin
          bytes_r <= cfg_wdata[16:0];
        end else begin
          base_r <= cfg_wdata;
        end
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    move_r   <= move_nxt;
    fr_ok_r  <= fr_ok_nxt;
    req_r    <= req_nxt;
    off_r    <= off_nxt;
    need_r   <= need_nxt;
    pos_r    <= pos_nxt;
    wpos_r   <= wpos_nxt;
    wval_r   <= wval_nxt;
    st_r     <= st_nxt;
    res_r    <= res_nxt;
    cfrom_r  <= cfrom_nxt;
    cbytes_r <= cbytes_nxt;
    if (load_out) begin
      if (st_r == ST_OK) begin
        od_r <= {5'b0, cbytes_r, cfrom_r, res_r, st_r};
      end else begin
        od_r <= {53'b0, st_r};
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

/* sv/iflf_checker.sv */
// ----------------------------------------------------------------------------
// iflf_checker
// Port-level checks for the first-fit allocator, bound to the top level.
// ----------------------------------------------------------------------------
module iflf_checker
  import iflf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[OUT_W-1:3] == '0)
    else $error("failed result carries offsets");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7)
    else $error("undefined status code");

endmodule

bind implicit_list_first_fit_allocator iflf_checker u_iflf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
